// ===== hdl/bpa_pkg.sv =====
`timescale 1ns / 1ps
// Shared codes and entry types for the buddy page allocator.
package bpa_pkg;

   localparam int ORDER_W = 4;

   // Operation codes on req_opcode
   localparam logic [1:0] OP_ALLOC   = 2'd0;
   localparam logic [1:0] OP_FREE    = 2'd1;
   localparam logic [1:0] OP_REBUILD = 2'd2;

   // Result codes on rsp_status
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_BAD_ORDER = 2'd1;
   localparam logic [1:0] ST_NO_MEM    = 2'd2;
   localparam logic [1:0] ST_IGNORED   = 2'd3;

   // Block order of a page that starts no block
   localparam logic [ORDER_W-1:0] ORDER_INNER = 4'd15;

   typedef logic [ORDER_W-1:0] order_type;

   // Per-page block descriptor
   typedef struct packed {
      order_type order;
      logic      alloc;
   } page_entry_type;

endpackage

// ===== hdl/bpa_page_mem.sv =====
`timescale 1ns / 1ps
// Per-page block descriptor and rebuild-order memories, one write and one read port.
module bpa_page_mem
   import bpa_pkg::*;
#(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  logic           clock,
   input  logic           entry_we,
   input  logic           top_we,
   input  logic [AW-1:0]  waddr,
   input  page_entry_type entry_wdata,
   input  order_type      top_wdata,
   input  logic [AW-1:0]  raddr,
   output page_entry_type entry_q,
   output order_type      top_q
);

   page_entry_type entry_mem [DEPTH];
   order_type      top_mem [DEPTH];

   always_ff @(posedge clock) begin
      if (entry_we) begin
         entry_mem[waddr] <= entry_wdata;
      end
      entry_q <= entry_mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (top_we) begin
         top_mem[waddr] <= top_wdata;
      end
      top_q <= top_mem[raddr];
   end

endmodule

// ===== hdl/bpa_link_mem.sv =====
`timescale 1ns / 1ps
// Free-list next and prev link memories, each with its own write port and a shared read address.
module bpa_link_mem
   import bpa_pkg::*;
#(
   parameter int DEPTH = 1024,
   parameter int AW    = 10,
   parameter int LW    = 11
) (
   input  logic          clock,
   input  logic          next_we,
   input  logic [AW-1:0] next_waddr,
   input  logic [LW-1:0] next_wdata,
   input  logic          prev_we,
   input  logic [AW-1:0] prev_waddr,
   input  logic [LW-1:0] prev_wdata,
   input  logic [AW-1:0] raddr,
   output logic [LW-1:0] next_q,
   output logic [LW-1:0] prev_q
);

   logic [LW-1:0] next_mem [DEPTH];
   logic [LW-1:0] prev_mem [DEPTH];

   always_ff @(posedge clock) begin
      if (next_we) begin
         next_mem[next_waddr] <= next_wdata;
      end
      next_q <= next_mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (prev_we) begin
         prev_mem[prev_waddr] <= prev_wdata;
      end
      prev_q <= prev_mem[raddr];
   end

endmodule

// ===== hdl/buddy_page_allocator.sv =====
`timescale 1ns / 1ps
// Buddy page allocator top level: command sequencer, free-list heads and result register.
//
//   channel | ports                                             | direction
//   req     | req_valid, req_stall, opcode, block_order, page    | in
//   rsp     | rsp_valid, rsp_stall, status, granted_page, pages  | out
//   csr     | csr_write_enable, csr_usable_pages                | in
//
// Allocate unlinks the lowest fitting free block and splits it down (up to MAX_ORDER split levels).
// Free merges with the buddy level by level; each level is a read of the buddy's
// descriptor and links through the registered memory ports.
// Rebuild sweeps every page once.
// Reset leaves all lists empty; frees are ignored until the first rebuild.
// One command is in flight; the next is taken while a result waits on rsp_stall.
module buddy_page_allocator
   import bpa_pkg::*;
#(
   parameter int NUM_PAGES = 1024,
   parameter int MAX_ORDER = 10
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [10:0] csr_usable_pages,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [3:0]  req_block_order,
   input  logic [9:0]  req_page_index,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [9:0]  rsp_granted_page,
   output logic [10:0] rsp_pages_in_use
);

   localparam int AW = $clog2(NUM_PAGES);
   localparam int LW = AW + 1;
   localparam int CW = $clog2(NUM_PAGES + 1);
   localparam int NL = MAX_ORDER + 1;
   localparam int HW = $clog2(NL);
   localparam logic [LW-1:0] LINK_NULL = LW'(NUM_PAGES);
   localparam logic [AW-1:0] LAST_PAGE = AW'(NUM_PAGES - 1);

   typedef enum logic [11:0] {
      S_IDLE     = 12'b0000_0000_0001,
      S_RB       = 12'b0000_0000_0010,
      S_AL_RD    = 12'b0000_0000_0100,
      S_AL_UNL   = 12'b0000_0000_1000,
      S_AL_SPLIT = 12'b0000_0001_0000,
      S_FR_RD    = 12'b0000_0010_0000,
      S_FR_CHK   = 12'b0000_0100_0000,
      S_FR_STEP  = 12'b0000_1000_0000,
      S_FR_BUD   = 12'b0001_0000_0000,
      S_FR_PUSH  = 12'b0010_0000_0000,
      S_FR_PUSH2 = 12'b0100_0000_0000,
      S_DONE     = 12'b1000_0000_0000
   } state_type;

   // Control state
   state_type     state_ff, state_in;
   logic [10:0]   usable_ff, usable_in;
   logic          built_ff, built_in;
   logic [CW-1:0] count_ff, count_in;
   logic [LW-1:0] head_ff [NL];
   logic [LW-1:0] head_in [NL];
   logic          pend_ff, pend_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // Working registers
   order_type     o_ff, o_in;
   order_type     k_ff, k_in;
   order_type     top_ff, top_in;
   logic [AW-1:0] pg_ff, pg_in;
   logic [AW-1:0] bud_ff, bud_in;
   logic [AW-1:0] hold_ff, hold_in;
   logic [LW-1:0] lim_ff, lim_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [LW-1:0] blk_next_ff, blk_next_in;
   order_type     blk_ord_ff, blk_ord_in;
   logic [AW-1:0] pend_addr_ff, pend_addr_in;
   logic [AW-1:0] pend_val_ff, pend_val_in;
   logic [1:0]    res_status_ff, res_status_in;
   logic [AW-1:0] res_granted_ff, res_granted_in;
   logic [1:0]    rsp_status_ff, rsp_status_in;
   logic [9:0]    rsp_granted_ff, rsp_granted_in;
   logic [10:0]   rsp_pages_ff, rsp_pages_in;

   // Memory ports
   logic           pe_we, top_we;
   logic [AW-1:0]  pe_waddr, pe_raddr;
   page_entry_type pe_wdata, pe_q;
   order_type      top_wdata, top_q;
   logic           nx_we, pv_we;
   logic [AW-1:0]  nx_waddr, pv_waddr, lk_raddr;
   logic [LW-1:0]  nx_wdata, pv_wdata, next_q, prev_q;

   // Helpers
   logic          head_ok [NL];
   logic          found;
   order_type     found_o;
   logic [HW-1:0] hd_idx;
   logic [LW-1:0] hd_rd;
   order_type     rb_ord;
   logic [LW-1:0] rb_rem;
   logic          rb_start, rb_in_range;
   logic [LW-1:0] bud_w;
   logic          req_take;

   bpa_page_mem #(.DEPTH(NUM_PAGES), .AW(AW)) u_page_mem (
      .clock       (clock),
      .entry_we    (pe_we),
      .top_we      (top_we),
      .waddr       (pe_waddr),
      .entry_wdata (pe_wdata),
      .top_wdata   (top_wdata),
      .raddr       (pe_raddr),
      .entry_q     (pe_q),
      .top_q       (top_q)
   );

   bpa_link_mem #(.DEPTH(NUM_PAGES), .AW(AW), .LW(LW)) u_link_mem (
      .clock      (clock),
      .next_we    (nx_we),
      .next_waddr (nx_waddr),
      .next_wdata (nx_wdata),
      .prev_we    (pv_we),
      .prev_waddr (pv_waddr),
      .prev_wdata (pv_wdata),
      .raddr      (lk_raddr),
      .next_q     (next_q),
      .prev_q     (prev_q)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_granted_page = rsp_granted_ff;
   assign rsp_pages_in_use = rsp_pages_ff;

   // Nonempty lists; lowest one at or above the requested order
   always_comb begin
      found   = 1'b0;
      found_o = '0;
      for (int o = 0; o < NL; o++) begin
         head_ok[o] = (head_ff[o] != LINK_NULL);
      end
      for (int o = NL - 1; o >= 0; o--) begin
         if (o >= int'(req_block_order) && head_ok[o]) begin
            found   = 1'b1;
            found_o = ORDER_W'(o);
         end
      end
   end

   // Rebuild: largest aligned block that fits at the sweep position
   always_comb begin
      int tz;
      int lg;
      int best;
      rb_rem      = lim_ff - {1'b0, idx_ff};
      rb_in_range = ({1'b0, idx_ff} < lim_ff);
      rb_start    = rb_in_range && ({1'b0, idx_ff} == blk_next_ff);
      tz = AW;
      for (int b = AW - 1; b >= 0; b--) begin
         if (idx_ff[b]) begin
            tz = b;
         end
      end
      lg = 0;
      for (int b = 0; b < LW; b++) begin
         if (rb_rem[b]) begin
            lg = b;
         end
      end
      best = MAX_ORDER;
      if (tz < best) begin
         best = tz;
      end
      if (lg < best) begin
         best = lg;
      end
      rb_ord = ORDER_W'(best);
   end

   // One read place into the head registers
   always_comb begin
      if (state_ff == S_IDLE) begin
         hd_idx = HW'(found_o);
      end else if (state_ff == S_RB) begin
         hd_idx = HW'(rb_ord);
      end else begin
         hd_idx = HW'(o_ff);
      end
      hd_rd = head_ff[hd_idx];
   end

   assign bud_w = {1'b0, pg_ff} ^ (LW'(1) << o_ff);

   // Sequencer
   always_comb begin
      state_in       = state_ff;
      usable_in      = usable_ff;
      built_in       = built_ff;
      count_in       = count_ff;
      head_in        = head_ff;
      pend_in        = pend_ff;
      rsp_valid_in   = rsp_valid_ff;
      o_in           = o_ff;
      k_in           = k_ff;
      top_in         = top_ff;
      pg_in          = pg_ff;
      bud_in         = bud_ff;
      hold_in        = hold_ff;
      lim_in         = lim_ff;
      idx_in         = idx_ff;
      blk_next_in    = blk_next_ff;
      blk_ord_in     = blk_ord_ff;
      pend_addr_in   = pend_addr_ff;
      pend_val_in    = pend_val_ff;
      res_status_in  = res_status_ff;
      res_granted_in = res_granted_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_granted_in = rsp_granted_ff;
      rsp_pages_in   = rsp_pages_ff;

      pe_we     = 1'b0;
      top_we    = 1'b0;
      pe_waddr  = pg_ff;
      pe_wdata  = '{order: ORDER_INNER, alloc: 1'b0};
      top_wdata = '0;
      pe_raddr  = pg_ff;
      nx_we     = 1'b0;
      nx_waddr  = pg_ff;
      nx_wdata  = LINK_NULL;
      pv_we     = 1'b0;
      pv_waddr  = pg_ff;
      pv_wdata  = LINK_NULL;
      lk_raddr  = pg_ff;

      if (csr_write_enable) begin
         usable_in = csr_usable_pages;
      end

      // Drop the result once the consumer takes it
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               res_granted_in = '0;
               state_in       = S_DONE;
               case (req_opcode)
                  OP_ALLOC: begin
                     if (int'(req_block_order) > MAX_ORDER) begin
                        res_status_in = ST_BAD_ORDER;
                     end else if (!found) begin
                        res_status_in = ST_NO_MEM;
                     end else begin
                        o_in     = found_o;
                        k_in     = req_block_order;
                        pg_in    = hd_rd[AW-1:0];
                        state_in = S_AL_RD;
                     end
                  end
                  OP_FREE: begin
                     if (32'(req_page_index) >= 32'(NUM_PAGES) || !built_ff) begin
                        res_status_in = ST_IGNORED;
                     end else begin
                        pg_in    = AW'(req_page_index);
                        state_in = S_FR_RD;
                     end
                  end
                  OP_REBUILD: begin
                     if (32'(usable_ff) > 32'(NUM_PAGES)) begin
                        lim_in = LINK_NULL;
                     end else begin
                        lim_in = LW'(usable_ff);
                     end
                     for (int o = 0; o < NL; o++) begin
                        head_in[o] = LINK_NULL;
                     end
                     count_in    = '0;
                     built_in    = 1'b0;
                     idx_in      = '0;
                     blk_next_in = '0;
                     blk_ord_in  = '0;
                     pend_in     = 1'b0;
                     state_in    = S_RB;
                  end
                  default: begin
                     res_status_in = ST_IGNORED;
                  end
               endcase
            end
         end

         S_RB: begin
            // Write one page per cycle; push each block start onto its list
            pe_we    = 1'b1;
            top_we   = 1'b1;
            pe_waddr = idx_ff;
            if (rb_start) begin
               pe_wdata           = '{order: rb_ord, alloc: 1'b0};
               top_wdata          = rb_ord;
               nx_we              = 1'b1;
               nx_waddr           = idx_ff;
               nx_wdata           = hd_rd;
               pv_we              = 1'b1;
               pv_waddr           = idx_ff;
               pv_wdata           = LINK_NULL;
               head_in[HW'(rb_ord)] = {1'b0, idx_ff};
               blk_next_in        = {1'b0, idx_ff} + (LW'(1) << rb_ord);
               blk_ord_in         = rb_ord;
               pend_in            = (hd_rd != LINK_NULL);
               pend_addr_in       = hd_rd[AW-1:0];
               pend_val_in        = idx_ff;
            end else begin
               top_wdata = rb_in_range ? blk_ord_ff : '0;
               if (pend_ff) begin
                  // Back-link the old head to the block pushed last cycle
                  pv_we    = 1'b1;
                  pv_waddr = pend_addr_ff;
                  pv_wdata = {1'b0, pend_val_ff};
                  pend_in  = 1'b0;
               end
            end
            idx_in = idx_ff + 1'b1;
            if (idx_ff == LAST_PAGE) begin
               built_in      = 1'b1;
               res_status_in = ST_OK;
               state_in      = S_DONE;
            end
         end

         S_AL_RD: begin
            lk_raddr = pg_ff;
            state_in = S_AL_UNL;
         end

         S_AL_UNL: begin
            // Unlink the head block; its prev is null
            head_in[HW'(o_ff)] = next_q;
            if (next_q != LINK_NULL) begin
               pv_we    = 1'b1;
               pv_waddr = next_q[AW-1:0];
               pv_wdata = LINK_NULL;
            end
            state_in = S_AL_SPLIT;
         end

         S_AL_SPLIT: begin
            if (o_ff > k_ff) begin
               // Upper half goes onto a list that is known to be empty
               o_in     = o_ff - 1'b1;
               pe_we    = 1'b1;
               pe_waddr = pg_ff + (AW'(1) << o_in);
               pe_wdata = '{order: o_in, alloc: 1'b0};
               nx_we    = 1'b1;
               nx_waddr = pe_waddr;
               nx_wdata = LINK_NULL;
               pv_we    = 1'b1;
               pv_waddr = pe_waddr;
               pv_wdata = LINK_NULL;
               head_in[HW'(o_in)] = {1'b0, pe_waddr};
            end else begin
               pe_we          = 1'b1;
               pe_waddr       = pg_ff;
               pe_wdata       = '{order: k_ff, alloc: 1'b1};
               count_in       = count_ff + (CW'(1) << k_ff);
               res_status_in  = ST_OK;
               res_granted_in = pg_ff;
               state_in       = S_DONE;
            end
         end

         S_FR_RD: begin
            pe_raddr = pg_ff;
            state_in = S_FR_CHK;
         end

         S_FR_CHK: begin
            if (!pe_q.alloc || int'(pe_q.order) > MAX_ORDER) begin
               res_status_in = ST_IGNORED;
               state_in      = S_DONE;
            end else begin
               o_in   = pe_q.order;
               top_in = top_q;
               if (count_ff >= (CW'(1) << pe_q.order)) begin
                  count_in = count_ff - (CW'(1) << pe_q.order);
               end else begin
                  count_in = '0;
               end
               state_in = S_FR_STEP;
            end
         end

         S_FR_STEP: begin
            if (o_ff < top_ff && int'(o_ff) < MAX_ORDER && bud_w < LINK_NULL) begin
               bud_in   = bud_w[AW-1:0];
               pe_raddr = bud_w[AW-1:0];
               lk_raddr = bud_w[AW-1:0];
               state_in = S_FR_BUD;
            end else begin
               state_in = S_FR_PUSH;
            end
         end

         S_FR_BUD: begin
            if (pe_q.order != o_ff || pe_q.alloc) begin
               state_in = S_FR_PUSH;
            end else begin
               // Unlink the buddy and fold the pair into one block
               if (prev_q != LINK_NULL) begin
                  nx_we    = 1'b1;
                  nx_waddr = prev_q[AW-1:0];
                  nx_wdata = next_q;
               end else begin
                  head_in[HW'(o_ff)] = next_q;
               end
               if (next_q != LINK_NULL) begin
                  pv_we    = 1'b1;
                  pv_waddr = next_q[AW-1:0];
                  pv_wdata = prev_q;
               end
               pe_we    = 1'b1;
               pe_wdata = '{order: ORDER_INNER, alloc: 1'b0};
               if (bud_ff < pg_ff) begin
                  pe_waddr = pg_ff;
                  pg_in    = bud_ff;
               end else begin
                  pe_waddr = bud_ff;
               end
               o_in     = o_ff + 1'b1;
               state_in = S_FR_STEP;
            end
         end

         S_FR_PUSH: begin
            pe_we              = 1'b1;
            pe_waddr           = pg_ff;
            pe_wdata           = '{order: o_ff, alloc: 1'b0};
            nx_we              = 1'b1;
            nx_waddr           = pg_ff;
            nx_wdata           = hd_rd;
            pv_we              = 1'b1;
            pv_waddr           = pg_ff;
            pv_wdata           = LINK_NULL;
            head_in[HW'(o_ff)] = {1'b0, pg_ff};
            hold_in            = hd_rd[AW-1:0];
            if (hd_rd != LINK_NULL) begin
               state_in = S_FR_PUSH2;
            end else begin
               res_status_in = ST_OK;
               state_in      = S_DONE;
            end
         end

         S_FR_PUSH2: begin
            pv_we         = 1'b1;
            pv_waddr      = hold_ff;
            pv_wdata      = {1'b0, pg_ff};
            res_status_in = ST_OK;
            state_in      = S_DONE;
         end

         S_DONE: begin
            // Hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = res_status_ff;
               rsp_granted_in = 10'(res_granted_ff);
               rsp_pages_in   = 11'(count_ff);
               state_in       = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         usable_ff    <= 11'd1024;
         built_ff     <= 1'b0;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int o = 0; o < NL; o++) begin
            head_ff[o] <= LINK_NULL;
         end
      end else begin
         state_ff     <= state_in;
         usable_ff    <= usable_in;
         built_ff     <= built_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         head_ff      <= head_in;
      end
   end

   always_ff @(posedge clock) begin
      o_ff           <= o_in;
      k_ff           <= k_in;
      top_ff         <= top_in;
      pg_ff          <= pg_in;
      bud_ff         <= bud_in;
      hold_ff        <= hold_in;
      lim_ff         <= lim_in;
      idx_ff         <= idx_in;
      blk_next_ff    <= blk_next_in;
      blk_ord_ff     <= blk_ord_in;
      pend_addr_ff   <= pend_addr_in;
      pend_val_ff    <= pend_val_in;
      res_status_ff  <= res_status_in;
      res_granted_ff <= res_granted_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_pages_ff   <= rsp_pages_in;
   end

   // The allocated page count never exceeds the zone
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= 32'(NUM_PAGES))
      else $error("allocated page count exceeds zone size");

   // Only a successful allocate grants a nonzero page
   a_granted_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != ST_OK) |-> (rsp_granted_ff == 10'd0))
      else $error("granted page set on a failed command");

   // Splitting never goes below the requested order
   a_split_floor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_AL_SPLIT) |-> (o_ff >= k_ff))
      else $error("split went below requested order");

   // The rebuild sweep ends with the zone marked built
   a_rebuild_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RB && idx_ff == LAST_PAGE) |=> (built_ff && state_ff == S_DONE))
      else $error("rebuild did not complete");

endmodule

// ===== verif/buddy_page_allocator_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the buddy page allocator: directed and random command streams.
module buddy_page_allocator_tb;
   import bpa_pkg::*;

   localparam int NPG     = 1024;
   localparam int MAXORD  = 10;
   localparam int NLIST   = MAXORD + 1;
   localparam int NULLPG  = NPG;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic [10:0] csr_usable_pages = 11'd0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_opcode = OP_ALLOC;
   logic [3:0]  req_block_order = 4'd0;
   logic [9:0]  req_page_index = 10'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_status;
   logic [9:0]  rsp_granted_page;
   logic [10:0] rsp_pages_in_use;

   always #10 clock = ~clock;

   buddy_page_allocator dut (
      .clock(clock), .reset(reset),
      .csr_write_enable(csr_write_enable), .csr_usable_pages(csr_usable_pages),
      .req_valid(req_valid), .req_stall(req_stall), .req_opcode(req_opcode),
      .req_block_order(req_block_order), .req_page_index(req_page_index),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_status(rsp_status),
      .rsp_granted_page(rsp_granted_page), .rsp_pages_in_use(rsp_pages_in_use)
   );

   typedef struct packed {
      logic [1:0]  status;
      logic [9:0]  page;
      logic [10:0] in_use;
   } outcome_type;

   // Shadow of the allocator state
   logic [10:0] shadow_usable;
   logic [3:0]  blk_order [NPG];
   logic        blk_alloc [NPG];
   logic [3:0]  top_order [NPG];
   int          next_lnk [NPG];
   int          prev_lnk [NPG];
   int          list_head [NLIST];
   int          list_len [NLIST];
   int          pages_used;

   outcome_type pending_outcomes[$];
   int          failures = 0;
   int          send_idle_pct = 0;
   int          stall_pct = 0;
   // Pages currently handed out, so frees usually hit live blocks
   int          live_pages[$];

   function automatic void push_free(int o, int p);
      next_lnk[p] = list_head[o];
      prev_lnk[p] = NULLPG;
      if (list_head[o] < NPG) prev_lnk[list_head[o]] = p;
      list_head[o] = p;
      list_len[o]++;
   endfunction

   function automatic void unlink_free(int o, int p);
      int n;
      int pr;
      n = next_lnk[p];
      pr = prev_lnk[p];
      if (pr < NPG) next_lnk[pr] = n;
      else list_head[o] = n;
      if (n < NPG) prev_lnk[n] = pr;
      if (list_len[o] > 0) list_len[o]--;
   endfunction

   function automatic void wipe_shadow();
      for (int i = 0; i < NPG; i++) begin
         blk_order[i] = ORDER_INNER;
         blk_alloc[i] = 1'b0;
         top_order[i] = 4'd0;
         next_lnk[i] = NULLPG;
         prev_lnk[i] = NULLPG;
      end
      for (int i = 0; i < NLIST; i++) begin
         list_head[i] = NULLPG;
         list_len[i] = 0;
      end
      pages_used = 0;
   endfunction

   // Compute the response to one command and advance the shadow state
   function automatic outcome_type allocator_outcome(logic [1:0] op, logic [3:0] k,
                                                     logic [9:0] pg_in);
      outcome_type r;
      int o;
      int p;
      int b;
      int pg;
      int lim;
      int t;
      r = '0;
      pg = int'(pg_in);
      if (op == OP_ALLOC) begin
         if (k > MAXORD) r.status = ST_BAD_ORDER;
         else begin
            o = int'(k);
            while (o <= MAXORD && list_len[o] == 0) o++;
            if (o > MAXORD || list_head[o] >= NPG) r.status = ST_NO_MEM;
            else begin
               p = list_head[o];
               unlink_free(o, p);
               while (o > k) begin
                  o--;
                  b = p + (1 << o);
                  blk_order[b] = 4'(o);
                  push_free(o, b);
               end
               blk_order[p] = k;
               blk_alloc[p] = 1'b1;
               pages_used += 1 << k;
               r.page = 10'(p);
               live_pages.push_back(p);
            end
         end
      end else if (op == OP_FREE) begin
         if (!blk_alloc[pg] || blk_order[pg] > MAXORD) r.status = ST_IGNORED;
         else begin
            o = int'(blk_order[pg]);
            blk_alloc[pg] = 1'b0;
            pages_used = (pages_used >= (1 << o)) ? pages_used - (1 << o) : 0;
            while (o < top_order[pg] && o < MAXORD) begin
               b = pg ^ (1 << o);
               if (b >= NPG || blk_order[b] != o || blk_alloc[b]) break;
               unlink_free(o, b);
               if (b < pg) begin
                  t = b; b = pg; pg = t;
               end
               blk_order[b] = ORDER_INNER;
               blk_order[pg] = 4'(o + 1);
               o++;
            end
            push_free(o, pg);
            foreach (live_pages[i])
               if (live_pages[i] == pg_in) begin
                  live_pages.delete(i);
                  break;
               end
         end
      end else if (op == OP_REBUILD) begin
         lim = (shadow_usable > NPG) ? NPG : int'(shadow_usable);
         wipe_shadow();
         live_pages.delete();
         p = 0;
         while (p < lim) begin
            o = 0;
            while (o < MAXORD && (p & ((2 << o) - 1)) == 0 && (2 << o) <= lim - p) o++;
            for (int i = 0; i < (1 << o); i++) top_order[p + i] = 4'(o);
            blk_order[p] = 4'(o);
            push_free(o, p);
            p += 1 << o;
         end
      end else r.status = ST_IGNORED;
      r.in_use = 11'(pages_used);
      return r;
   endfunction

   // Send one command: hold valid until the transfer, predict at acceptance
   task automatic send_cmd(logic [1:0] op, logic [3:0] k, logic [9:0] pg);
      @(posedge clock);
      while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      req_valid <= 1'b1;
      req_opcode <= op;
      req_block_order <= k;
      req_page_index <= pg;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_outcomes.push_back(allocator_outcome(op, k, pg));
      req_valid <= 1'b0;
   endtask

   // Drain outstanding results, then let the block settle before a register write
   task automatic settle();
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (NPG + 40) @(posedge clock);
   endtask

   task automatic write_usable(logic [10:0] v);
      settle();
      csr_write_enable <= 1'b1;
      csr_usable_pages <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      shadow_usable = v;
   endtask

   // Receiver: random stall, compare each transfer with the oldest expectation
   always @(posedge clock) begin
      outcome_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_outcomes.size() == 0) begin
               $display("%0t unexpected result status=%0d page=%0d in_use=%0d",
                        $time, rsp_status, rsp_granted_page, rsp_pages_in_use);
               failures++;
            end else begin
               want = pending_outcomes.pop_front();
               if (rsp_status !== want.status) begin
                  $display("%0t status expected %0d actual %0d", $time, want.status, rsp_status);
                  failures++;
               end
               if (rsp_granted_page !== want.page) begin
                  $display("%0t granted_page expected %0d actual %0d",
                           $time, want.page, rsp_granted_page);
                  failures++;
               end
               if (rsp_pages_in_use !== want.in_use) begin
                  $display("%0t pages_in_use expected %0d actual %0d",
                           $time, want.in_use, rsp_pages_in_use);
                  failures++;
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Directed: before any rebuild, then extremes, every opcode and special case
   task automatic test_directed();
      send_cmd(OP_ALLOC, 4'd0, 10'd0);          // empty lists after reset
      send_cmd(OP_FREE, 4'd0, 10'd0);           // nothing allocated
      send_cmd(OP_REBUILD, 4'd0, 10'd0);        // reset value, full zone
      send_cmd(OP_ALLOC, 4'd10, 10'd0);         // whole zone
      send_cmd(OP_ALLOC, 4'd0, 10'd0);          // out of memory
      send_cmd(OP_ALLOC, 4'd11, 10'd0);         // illegal order
      send_cmd(OP_ALLOC, 4'd15, 10'h3FF);
      send_cmd(OP_FREE, 4'd15, 10'd0);          // free the whole zone
      send_cmd(OP_ALLOC, 4'd0, 10'd0);          // split down ten levels
      send_cmd(OP_ALLOC, 4'd0, 10'd0);
      send_cmd(OP_FREE, 4'd0, 10'd1);           // buddy page 0 still allocated, no merge
      send_cmd(OP_FREE, 4'd0, 10'd1);           // double free
      send_cmd(OP_FREE, 4'd0, 10'd0);           // merge all the way up
      send_cmd(OP_ALLOC, 4'd3, 10'd0);
      send_cmd(OP_FREE, 4'd0, 10'd4);           // not a block start
      send_cmd(OP_FREE, 4'd0, 10'h3FF);
      send_cmd(2'd3, 4'd15, 10'h3FF);           // unknown opcode
      write_usable(11'd2047);                   // clamped to the zone size
      send_cmd(OP_REBUILD, 4'd0, 10'd0);
      write_usable(11'd0);                      // empty zone
      send_cmd(OP_REBUILD, 4'd0, 10'd0);
      send_cmd(OP_ALLOC, 4'd0, 10'd0);
      write_usable(11'd1023);                   // odd sizes cut into many blocks
      send_cmd(OP_REBUILD, 4'd0, 10'd0);
      send_cmd(OP_ALLOC, 4'd9, 10'd0);
   endtask

   // Random: mostly allocate/free of live blocks, some noise and rebuilds
   task automatic test_random(int count, logic [10:0] usable);
      int sel;
      logic [9:0] pg;
      write_usable(usable);
      send_cmd(OP_REBUILD, 4'd0, 10'd0);
      for (int i = 0; i < count; i++) begin
         sel = $urandom_range(99);
         if (sel < 45)
            send_cmd(OP_ALLOC,
                     4'(($urandom_range(9) < 8) ? $urandom_range(4) : $urandom_range(15)),
                     10'($urandom));
         else if (sel < 85 && live_pages.size() != 0) begin
            pg = 10'(live_pages[$urandom_range(live_pages.size() - 1)]);
            send_cmd(OP_FREE, 4'($urandom), pg);
         end else if (sel < 97)
            send_cmd(OP_FREE, 4'($urandom), 10'($urandom));
         else if (sel < 99)
            send_cmd(2'd3, 4'($urandom), 10'($urandom));
         else
            send_cmd(OP_REBUILD, 4'($urandom), 10'($urandom));
      end
   endtask

   initial begin
      shadow_usable = 11'd1024;
      wipe_shadow();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(250, 11'd1024);
      send_idle_pct = 75;
      test_random(350, 11'd1);
      test_random(100, 11'd637);
      send_idle_pct = 0; stall_pct = 75;
      test_random(400, 11'd1024);
      send_idle_pct = 8; stall_pct = 8;
      test_random(300, 11'd200);
      send_idle_pct = 0; stall_pct = 0;
      test_random(300, 11'd1024);
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (NPG + 40) @(posedge clock);
      if (failures == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

   // Watchdog for a hung handshake
   initial begin
      #300ms;
      $display("tb: failure");
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/bpa_pkg.sv
hdl/bpa_page_mem.sv
hdl/bpa_link_mem.sv
hdl/buddy_page_allocator.sv
verif/buddy_page_allocator_tb.sv
